/* src/rls_pkg.sv */
// Package: command, status and word types shared by the stack unit and its interfaces.
`timescale 1ns / 1ps
package rls_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 9;

  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_TOP     = 3'd2,
    CMD_BOTTOM  = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_REVERSE = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                      command;
    logic signed [VALUE_W-1:0] push_value;
  } cmd_word_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        entry_count;
  } rsp_word_t;

endpackage

/* src/rls_stream_if.sv */
// Interface: valid/ready channel carrying one word of a given payload type.
`timescale 1ns / 1ps
interface rls_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/reversible_lifo_stack_unit.sv */
// Top level: bounded LIFO stack of signed 32-bit values with constant-time reversal.
`timescale 1ns / 1ps
// The stack keeps up to STACK_DEPTH values in a ring held in one RAM; a base slot
// and a direction flag locate the bottom and the growth direction, so reverse
// only moves the base to the old top and flips the flag. Every command word gives
// one response word: status, value and the count after the command. Push, clear,
// reverse and unknown commands load the response register directly; pop, read top
// and read bottom on a non-empty stack wait for the RAM's registered read data.
// A response sits in an output register; the next command is taken as it drains.
// The RAM needs no clearing after reset: only slots written by a push are read.
module reversible_lifo_stack_unit #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst,
  rls_stream_if.sink   cmd,
  rls_stream_if.source rsp
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned XW = (CW > rls_pkg::COUNT_W) ? CW : rls_pkg::COUNT_W;
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(STACK_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t      state, state_next;
  logic [AW-1:0] base, base_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          top_low, top_low_next;

  rls_pkg::status_t                   o_status, status_next;
  logic signed [rls_pkg::VALUE_W-1:0] o_value;
  logic [CW-1:0]                      o_cnt;
  logic                               o_valid;

  logic          accept;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] k_sel;
  logic [AW:0]   sum_up, sum_dn;
  logic [AW-1:0] slot;
  logic          wr_en, rd_go;
  logic [AW-1:0] raddr;
  logic [rls_pkg::VALUE_W-1:0] rdata;
  logic [XW-1:0] cnt_x;

  assign cmd.ready = (state == S_IDLE) && (!o_valid || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;

  // Ring slot at distance k from the bottom, in the direction of growth.
  assign cnt_m1 = cnt - CW'(1);
  assign k_sel  = (cmd.data.command == rls_pkg::CMD_PUSH) ? cnt[AW-1:0] : cnt_m1[AW-1:0];
  assign sum_up = {1'b0, base} + {1'b0, k_sel};
  assign sum_dn = {1'b0, base} - {1'b0, k_sel};

  always_comb begin
    if (top_low) begin
      slot = sum_dn[AW] ? AW'(sum_dn + DEPTH_A) : sum_dn[AW-1:0];
    end else begin
      slot = (sum_up >= DEPTH_A) ? AW'(sum_up - DEPTH_A) : sum_up[AW-1:0];
    end
  end

  always_comb begin
    state_next   = state;
    base_next    = base;
    cnt_next     = cnt;
    top_low_next = top_low;
    status_next  = rls_pkg::ST_OK;
    wr_en        = 1'b0;
    rd_go        = 1'b0;
    raddr        = slot;
    if (state == S_READ) begin
      state_next = S_IDLE;
    end else if (accept) begin
      unique case (cmd.data.command) inside
        rls_pkg::CMD_PUSH: begin
          if (cnt == DEPTH_C) begin
            status_next = rls_pkg::ST_FULL;
          end else begin
            wr_en    = 1'b1;
            cnt_next = cnt + CW'(1);
          end
        end
        rls_pkg::CMD_POP, rls_pkg::CMD_TOP, rls_pkg::CMD_BOTTOM: begin
          if (cnt == '0) begin
            status_next = rls_pkg::ST_EMPTY;
          end else begin
            rd_go      = 1'b1;
            state_next = S_READ;
            if (cmd.data.command == rls_pkg::CMD_BOTTOM) begin
              raddr = base;
            end
            if (cmd.data.command == rls_pkg::CMD_POP) begin
              cnt_next = cnt_m1;
            end
          end
        end
        rls_pkg::CMD_CLEAR: begin
          cnt_next = '0;
        end
        rls_pkg::CMD_REVERSE: begin
          if (cnt != '0) begin
            base_next = slot;
          end
          top_low_next = !top_low;
        end
        default: begin
        end
      endcase
    end
  end

  rls_ram #(
    .WIDTH (rls_pkg::VALUE_W),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (slot),
    .wdata (cmd.data.push_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      base    <= '0;
      cnt     <= '0;
      top_low <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      base    <= base_next;
      cnt     <= cnt_next;
      top_low <= top_low_next;
      if (state == S_READ) begin
        o_valid <= 1'b1;
      end else if (accept) begin
        o_valid <= !rd_go;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Response payload; for a read the value is taken from the RAM's registered read data in the read state.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      o_value <= rdata;
    end else if (accept) begin
      o_status <= status_next;
      o_value  <= '0;
      o_cnt    <= cnt_next;
    end
  end

  assign cnt_x = XW'(o_cnt);

  assign rsp.valid            = o_valid;
  assign rsp.data.status      = o_status;
  assign rsp.data.read_value  = o_value;
  assign rsp.data.entry_count = cnt_x[rls_pkg::COUNT_W-1:0];

  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !o_valid)
    else $error("response register busy while a read is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= DEPTH_C)
    else $error("entry count above stack depth");

  a_base_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, base} < DEPTH_A)
    else $error("ring base outside the ring");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.data.command == rls_pkg::CMD_PUSH && cnt == DEPTH_C)
      |=> (o_valid && o_status == rls_pkg::ST_FULL && cnt == DEPTH_C))
    else $error("push on a full stack not refused");

endmodule

/* src/rls_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
module rls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
